### rtl/core/cdad_pkg.sv
// shared types, constants and month length function for the date adder
package cdad_pkg;

	localparam int DAY_FW   = 5;
	localparam int MONTH_FW = 4;
	localparam int YEAR_FW  = 14;
	localparam int ADD_FW   = 16;

	// year reduction: 400 shifted by 5 down to 0 covers any 14-bit year
	localparam int RED_STEPS = 6;
	localparam int RED_IDX_W = 3;
	localparam int RED_BASE  = 400;
	localparam int REM_LAST  = 399;
	localparam int CENT_1    = 100;
	localparam int CENT_2    = 200;
	localparam int CENT_3    = 300;

	localparam logic [MONTH_FW-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_FW-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_FW-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_FW-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_FW-1:0] MON_MAY = 4'd5;
	localparam logic [MONTH_FW-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_FW-1:0] MON_JUL = 4'd7;
	localparam logic [MONTH_FW-1:0] MON_AUG = 4'd8;
	localparam logic [MONTH_FW-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_FW-1:0] MON_OCT = 4'd10;
	localparam logic [MONTH_FW-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_FW-1:0] MON_DEC = 4'd12;

	localparam logic [DAY_FW-1:0] LEN_31 = 5'd31;
	localparam logic [DAY_FW-1:0] LEN_30 = 5'd30;
	localparam logic [DAY_FW-1:0] LEN_29 = 5'd29;
	localparam logic [DAY_FW-1:0] LEN_28 = 5'd28;

	typedef struct packed {
		logic [DAY_FW-1:0]   start_day;
		logic [MONTH_FW-1:0] start_month;
		logic [YEAR_FW-1:0]  start_year;
		logic [ADD_FW-1:0]   days_to_add;
	} req_t;

	typedef struct packed {
		logic [DAY_FW-1:0]   result_day;
		logic [MONTH_FW-1:0] result_month;
		logic [YEAR_FW-1:0]  result_year;
		logic                status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_STEP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 load;
		logic                 reduce;
		logic [RED_IDX_W-1:0] red_idx;
		logic                 add;
		logic                 step;
		logic                 out_load;
	} cmd_t;

	typedef struct packed {
		logic invalid;
		logic more;
	} sts_t;

	function automatic logic [DAY_FW-1:0] month_len(input logic [MONTH_FW-1:0] m,
			input logic leap);
		logic [DAY_FW-1:0] len;
		case (m)
			MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = LEN_31;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
			MON_FEB: len = leap ? LEN_29 : LEN_28;
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage

### rtl/core/cdad_ctrl.sv
// sequencer for the date adder: reduce, check, month steps, result hand-off
module cdad_ctrl import cdad_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_nxt;
	logic [RED_IDX_W-1:0] red_q;
	logic rsp_valid_q;
	logic out_free;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (red_q == '0) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = sts.invalid ? ST_FINISH : ST_STEP;
			end
			ST_STEP: begin
				if (!sts.more) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.red_idx = red_q;
		case (state_q)
			ST_IDLE:   cmd.load = req_valid;
			ST_REDUCE: cmd.reduce = 1'b1;
			ST_CHECK:  cmd.add = !sts.invalid;
			ST_STEP:   cmd.step = sts.more;
			ST_FINISH: cmd.out_load = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			red_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				red_q <= RED_IDX_W'(RED_STEPS - 1);
			end else if (cmd.reduce && red_q != '0) begin
				red_q <= red_q - 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/cdad_dp.sv
// datapath for the date adder: date registers, year residue, month stepper
module cdad_dp import cdad_pkg::*; #(
	parameter int ADD_BITS = 16
) (
	input  logic clk,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp
);

	localparam int DAY_W    = ADD_BITS + 1;
	localparam int USE_BITS = (ADD_BITS < ADD_FW) ? ADD_BITS : ADD_FW;

	logic [DAY_W-1:0]    day_q;
	logic [USE_BITS-1:0] add_q;
	logic [MONTH_FW-1:0] month_q;
	logic [YEAR_FW-1:0]  year_q;
	logic [YEAR_FW-1:0]  rem_q;
	rsp_t                rsp_q;

	logic [YEAR_FW:0]    sub_val;
	logic                leap;
	logic [DAY_FW-1:0]   len;
	logic [DAY_W-1:0]    len_ext;

	assign sub_val = (YEAR_FW + 1)'(RED_BASE) << cmd.red_idx;

	// year mod 400 gives both the mod 4 and the century tests
	assign leap = (rem_q[1:0] == 2'b00) && (rem_q != YEAR_FW'(CENT_1))
		&& (rem_q != YEAR_FW'(CENT_2)) && (rem_q != YEAR_FW'(CENT_3));
	assign len     = month_len(month_q, leap);
	assign len_ext = DAY_W'(len);

	assign sts.invalid = (month_q < MON_JAN) || (month_q > MON_DEC)
		|| (day_q == '0) || (day_q > len_ext);
	assign sts.more = (day_q > len_ext);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= DAY_W'(req.start_day);
			add_q   <= req.days_to_add[USE_BITS-1:0];
			month_q <= req.start_month;
			year_q  <= req.start_year;
			rem_q   <= req.start_year;
		end else if (cmd.reduce) begin
			if ({1'b0, rem_q} >= sub_val) rem_q <= rem_q - sub_val[YEAR_FW-1:0];
		end else if (cmd.add) begin
			day_q <= day_q + DAY_W'(add_q);
		end else if (cmd.step) begin
			day_q <= day_q - len_ext;
			if (month_q == MON_DEC) begin
				month_q <= MON_JAN;
				year_q  <= year_q + 1'b1;
				rem_q   <= (rem_q == YEAR_FW'(REM_LAST)) ? '0 : rem_q + 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
		if (cmd.out_load) begin
			if (sts.invalid) begin
				rsp_q.result_day   <= '0;
				rsp_q.result_month <= '0;
				rsp_q.result_year  <= '0;
				rsp_q.status       <= 1'b1;
			end else begin
				rsp_q.result_day   <= day_q[DAY_FW-1:0];
				rsp_q.result_month <= month_q;
				rsp_q.result_year  <= year_q;
				rsp_q.status       <= 1'b0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/core/calendar_date_add_days_top.sv
// top level of the gregorian date adder
// the result follows the year reduction, the date check and N month steps, N = months advanced
// (N at most about 2154 with ADD_BITS = 16), as the step loop advances one month per cycle;
// an invalid start date skips the loop and goes straight to the result hand-off
// one transaction at a time: a new request is taken only once the last result is loaded for output
// reset: arst_n clears the sequencer and the result valid flag, date registers hold no reset
module calendar_date_add_days_top import cdad_pkg::*; #(
	parameter int ADD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// request channel: start date and day count
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	// response channel: result date and status
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: year reduction count, check, month loop, output hand-off
	cdad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: holds the date, year mod 400 and the registered result
	cdad_dp #(
		.ADD_BITS (ADD_BITS)
	) u_dp (
		.clk (clk),
		.req (req),
		.cmd (cmd),
		.sts (sts),
		.rsp (rsp)
	);

endmodule
